FILE: hdl/srsw_pkg.sv
`default_nettype none

package srsw_pkg;

  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_W        = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_BITS = 32;
  localparam int WIN_W        = 3;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

  typedef logic [SEQ_W-1:0]        seq_t;
  typedef logic [SEQ_SPACE-1:0]    seq_mask_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [WIN_W-1:0]        win_t;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  // Outcome of one event, handed from the window control to the result register
  typedef struct packed {
    logic accepted;
    logic tx_valid;
    logic resend;
    seq_t tx_seq;
    logic t_start;
    logic t_stop;
    seq_t t_seq;
    logic window_full;
    seq_t base;
    seq_t next;
  } step_res_t;

endpackage

`default_nettype wire

FILE: hdl/srsw_ifs.sv
`default_nettype none

interface srsw_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  srsw_pkg::payload_t    payload;
  srsw_pkg::seq_t        ack_seq;
  logic                  ack_check_ok;
  srsw_pkg::seq_t        timeout_seq;

  modport source (output valid, kind, payload, ack_seq, ack_check_ok, timeout_seq,
                  input ready);
  modport sink   (input valid, kind, payload, ack_seq, ack_check_ok, timeout_seq,
                  output ready);
endinterface

interface srsw_out_if;
  logic                  valid;
  logic                  ready;
  logic                  send_accepted;
  logic                  tx_valid;
  srsw_pkg::seq_t        tx_seq;
  srsw_pkg::payload_t    tx_payload;
  logic                  timer_start;
  logic                  timer_stop;
  srsw_pkg::seq_t        timer_seq;
  logic                  window_full;
  srsw_pkg::seq_t        base_seq;
  srsw_pkg::seq_t        next_seq;

  modport source (output valid, send_accepted, tx_valid, tx_seq, tx_payload, timer_start,
                  timer_stop, timer_seq, window_full, base_seq, next_seq,
                  input ready);
  modport sink   (input valid, send_accepted, tx_valid, tx_seq, tx_payload, timer_start,
                  timer_stop, timer_seq, window_full, base_seq, next_seq,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/srsw_ctrl.sv
`default_nettype none

module srsw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire srsw_pkg::win_t      cfg_wr_data,
  input  wire logic                step_en,
  input  wire logic [1:0]          kind,
  input  wire srsw_pkg::seq_t      ack_seq,
  input  wire logic                ack_check_ok,
  input  wire srsw_pkg::seq_t      timeout_seq,
  output srsw_pkg::step_res_t      res
);

  srsw_pkg::win_t      win_r;
  srsw_pkg::seq_t      base_r, base_nxt;
  srsw_pkg::seq_t      next_r, next_nxt;
  srsw_pkg::seq_mask_t mask_r, mask_nxt;

  srsw_pkg::seq_mask_t                 mask_clr;
  logic [2*srsw_pkg::SEQ_SPACE-1:0]    rot_wide;
  srsw_pkg::seq_mask_t                 rot;
  srsw_pkg::seq_t                      scan_base;
  logic                                full_pre;

  always_comb begin
    mask_clr          = mask_r;
    mask_clr[ack_seq] = 1'b0;
    // rotate so that bit 0 is the base, then take the nearest set bit after it
    rot_wide  = {mask_clr, mask_clr} >> base_r;
    rot       = rot_wide[srsw_pkg::SEQ_SPACE-1:0];
    scan_base = base_r + srsw_pkg::seq_t'(1);
    for (int i = srsw_pkg::SEQ_SPACE - 1; i >= 1; i--) begin
      if (rot[i]) begin
        scan_base = base_r + srsw_pkg::seq_t'(i);
      end
    end
  end

  always_comb begin
    base_nxt = base_r;
    next_nxt = next_r;
    mask_nxt = mask_r;
    res      = '0;
    full_pre = srsw_pkg::win_t'(next_r - base_r) >= win_r;
    unique case (kind)
      srsw_pkg::KIND_SEND: begin
        if (!full_pre && !mask_r[next_r]) begin
          if (mask_r == '0) begin
            base_nxt = next_r;
          end
          mask_nxt[next_r] = 1'b1;
          res.accepted     = 1'b1;
          res.tx_valid     = 1'b1;
          res.tx_seq       = next_r;
          res.t_start      = 1'b1;
          res.t_seq        = next_r;
          next_nxt         = next_r + srsw_pkg::seq_t'(1);
        end
      end
      srsw_pkg::KIND_ACK: begin
        if (ack_check_ok && mask_r[ack_seq]) begin
          mask_nxt = mask_clr;
          if (ack_seq == base_r) begin
            base_nxt = scan_base;
          end
          res.t_stop = 1'b1;
          res.t_seq  = ack_seq;
        end
      end
      srsw_pkg::KIND_TIMEOUT: begin
        res.t_stop = 1'b1;
        res.t_seq  = timeout_seq;
        if (mask_r[timeout_seq]) begin
          res.t_start  = 1'b1;
          res.tx_valid = 1'b1;
          res.resend   = 1'b1;
          res.tx_seq   = timeout_seq;
        end
      end
      default: begin
      end
    endcase
    res.window_full = srsw_pkg::win_t'(next_nxt - base_nxt) >= win_r;
    res.base        = base_nxt;
    res.next        = next_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= srsw_pkg::WIN_RESET;
      base_r <= '0;
      next_r <= '0;
      mask_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (step_en) begin
        base_r <= base_nxt;
        next_r <= next_nxt;
        mask_r <= mask_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/selective_repeat_sender_window_unit.sv
// Each event's result is loaded into the output register on its input transfer.
// Throughput: one event per cycle; the input stays open whenever the output register
// is empty or being drained in the same cycle.
// Reset: window size returns to 4, base, next number and outstanding set clear, output
// register empties. The resend store is not cleared; only entries written are read.
`default_nettype none

module selective_repeat_sender_window_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire srsw_pkg::win_t cfg_wr_data,
  srsw_in_if.sink             in_chan,
  srsw_out_if.source          out_chan
);

  logic                  step_en;
  srsw_pkg::step_res_t   res;
  srsw_pkg::step_res_t   res_r;
  srsw_pkg::payload_t    tx_payload_r;
  logic                  out_valid_r;

  srsw_pkg::payload_t    resend_mem [srsw_pkg::SEQ_SPACE];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign step_en       = in_chan.valid && in_chan.ready;

  srsw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .step_en      (step_en),
    .kind         (in_chan.kind),
    .ack_seq      (in_chan.ack_seq),
    .ack_check_ok (in_chan.ack_check_ok),
    .timeout_seq  (in_chan.timeout_seq),
    .res          (res)
  );

  // store the payload of an accepted send; load the result register on each transfer
  always_ff @(posedge clk) begin
    if (step_en) begin
      if (res.accepted) begin
        resend_mem[res.tx_seq] <= in_chan.payload;
      end
      res_r <= res;
      if (res.resend) begin
        tx_payload_r <= resend_mem[in_chan.timeout_seq];
      end else if (res.accepted) begin
        tx_payload_r <= in_chan.payload;
      end else begin
        tx_payload_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.send_accepted = res_r.accepted;
  assign out_chan.tx_valid      = res_r.tx_valid;
  assign out_chan.tx_seq        = res_r.tx_seq;
  assign out_chan.tx_payload    = tx_payload_r;
  assign out_chan.timer_start   = res_r.t_start;
  assign out_chan.timer_stop    = res_r.t_stop;
  assign out_chan.timer_seq     = res_r.t_seq;
  assign out_chan.window_full   = res_r.window_full;
  assign out_chan.base_seq      = res_r.base;
  assign out_chan.next_seq      = res_r.next;

endmodule

`default_nettype wire
